// ===== design/stg_pkg.sv =====
package stg_pkg;

    localparam int SINE_TABLE_ENTRIES_DEF = 1024;
    localparam int PHASE_BITS_DEF         = 32;

    localparam int AUDIO_RATE_HZ = 44100;
    localparam int NYQUIST_HZ    = 22050;
    localparam int AMPLITUDE     = 12000;
    localparam int MAG_W         = 14;
    localparam int SAMPLE_W      = 15;
    localparam int HZ_W          = 15;
    localparam int MS_W          = 16;
    localparam int COUNT_W       = 22;
    localparam int VOL_W         = 7;

    // floor(ms * 441 / 10) == (ms * MS_RECIP) >> MS_SHIFT for every 16-bit ms
    localparam int MS_SHIFT   = 20;
    localparam int MS_RECIP   = ((AUDIO_RATE_HZ / 100) * (1 << MS_SHIFT) + 9) / 10;
    localparam int MS_RECIP_W = 26;
    localparam int MS_PROD_W  = MS_W + MS_RECIP_W;

    // fraction bits of the phase step reciprocal, exact for tone_hz up to nyquist
    localparam int STEP_FRAC_SHIFT = 31;

    // floor(x / 100) == (x * VOL_RECIP) >> VOL_SHIFT for x below 6e6
    localparam int VOL_FULL  = 100;
    localparam int VOL_RECIP = 2684355;
    localparam int VOL_SHIFT = 28;
    localparam int FACTOR_W  = 28;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic            op;
        logic [HZ_W-1:0] tone_hz;
        logic [MS_W-1:0] duration_ms;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       tone_active;
    } out_t;

endpackage

// ===== design/stg_start_div.sv =====
module stg_start_div #(
    parameter int PHASE_BITS = stg_pkg::PHASE_BITS_DEF
) (
    input  logic [stg_pkg::HZ_W-1:0]     tone_hz,
    input  logic [stg_pkg::MS_W-1:0]     duration_ms,
    output logic [PHASE_BITS-1:0]        step,
    output logic [stg_pkg::COUNT_W-1:0]  samples
);
    import stg_pkg::*;

    // step = hz * whole + floor(hz * rem / rate), the second term by reciprocal
    localparam longint unsigned FULL_TURN  = 64'd1 << PHASE_BITS;
    localparam longint unsigned RATE_U     = 64'(AUDIO_RATE_HZ);
    localparam longint unsigned STEP_WHOLE = FULL_TURN / RATE_U;
    localparam longint unsigned STEP_REM   = FULL_TURN - STEP_WHOLE * RATE_U;
    localparam longint unsigned STEP_FRAC  =
        ((STEP_REM << STEP_FRAC_SHIFT) + RATE_U - 64'd1) / RATE_U;
    localparam int FRAC_W = HZ_W + STEP_FRAC_SHIFT;

    logic [HZ_W-1:0]       hz_sat;
    logic [PHASE_BITS-1:0] whole_part;
    logic [FRAC_W-1:0]     frac_prod;
    logic [MS_PROD_W-1:0]  ms_prod;

    assign hz_sat     = (tone_hz > HZ_W'(NYQUIST_HZ)) ? HZ_W'(NYQUIST_HZ) : tone_hz;
    assign whole_part = PHASE_BITS'(hz_sat) * PHASE_BITS'(STEP_WHOLE);
    assign frac_prod  = FRAC_W'(hz_sat) * FRAC_W'(STEP_FRAC);
    assign step       = whole_part + PHASE_BITS'(frac_prod[STEP_FRAC_SHIFT +: HZ_W]);
    assign ms_prod    = MS_PROD_W'(duration_ms) * MS_PROD_W'(MS_RECIP);
    assign samples    = ms_prod[MS_SHIFT +: COUNT_W];

endmodule

// ===== design/stg_sine_rom.sv =====
module stg_sine_rom #(
    parameter int SINE_TABLE_ENTRIES = stg_pkg::SINE_TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] idx,
    output logic [stg_pkg::MAG_W-1:0]         mag,
    output logic                              neg
);
    import stg_pkg::*;

    localparam int KW    = $clog2(SINE_TABLE_ENTRIES);
    localparam int QW    = KW + 2;
    localparam int DEPTH = SINE_TABLE_ENTRIES + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [63:0] HALF_PI_Q32 = 64'h1_921F_B544;

    typedef logic [MAG_W-1:0] rom_t [DEPTH];

    // 12000 * sin((pi/2) * num / N), truncated, Q30 Taylor series
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] num);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag_w;
        logic signed [63:0] sum;
        if (num == 64'd0)
            return '0;
        if (num >= 64'(SINE_TABLE_ENTRIES))
            return MAG_W'(AMPLITUDE);
        x    = ((num * HALF_PI_Q32) / SINE_TABLE_ENTRIES) >> 2;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 210;
        sum  = sum - $signed(term);
        if (sum <= 0)
            return '0;
        mag_w = ($unsigned(sum) * 64'(AMPLITUDE)) >> 30;
        if (mag_w > 64'(AMPLITUDE))
            mag_w = 64'(AMPLITUDE);
        return MAG_W'(mag_w);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < DEPTH; i++)
        begin
            r[i] = quarter_sine(64'(i));
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    localparam logic [QW-1:0] N1 = QW'(SINE_TABLE_ENTRIES);
    localparam logic [QW-1:0] N2 = QW'(2 * SINE_TABLE_ENTRIES);
    localparam logic [QW-1:0] N3 = QW'(3 * SINE_TABLE_ENTRIES);

    logic [QW-1:0] four;
    logic [1:0]    quad;
    logic [QW-1:0] rem;
    logic [AW-1:0] addr;

    assign four = {idx, 2'b00};

    // quadrant of the table index
    always_comb
    begin
        if (four >= N3)
        begin
            quad = 2'd3;
            rem  = four - N3;
        end
        else if (four >= N2)
        begin
            quad = 2'd2;
            rem  = four - N2;
        end
        else if (four >= N1)
        begin
            quad = 2'd1;
            rem  = four - N1;
        end
        else
        begin
            quad = 2'd0;
            rem  = four;
        end
    end

    assign addr = quad[0] ? AW'(N1 - rem) : AW'(rem);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mag <= SINE_ROM[addr];
            neg <= quad[1];
        end
    end

endmodule

// ===== design/sine_tone_generator_with_volume.sv =====
// Sine tone generator for a 44.1 kHz stream with a volume register. A start
// request (op 0) clears the phase and loads the tone's phase step and sample
// count at the edge that accepts it; it gives no result and never stalls the
// input. Tick requests (op 1) are taken one per cycle and pass three register
// stages (table index, sine ROM read, volume scaling) before out_valid rises;
// in_ready drops only while the output is stalled and every stage holds a
// request. An idle tick yields 0 with tone_active low. The user must write
// volume through cfg_we / cfg_wdata only while no request is in flight; the
// block does not enforce this. 100 and above pass samples as is.
module sine_tone_generator_with_volume #(
    parameter int SINE_TABLE_ENTRIES = stg_pkg::SINE_TABLE_ENTRIES_DEF,
    parameter int PHASE_BITS         = stg_pkg::PHASE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [stg_pkg::VOL_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  stg_pkg::in_t              in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output stg_pkg::out_t             out_data
);
    import stg_pkg::*;

    localparam int KW     = $clog2(SINE_TABLE_ENTRIES);
    localparam int IDXP_W = 16 + $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PROD_W = MAG_W + FACTOR_W;

    logic                  accept;
    logic                  tick_go;
    logic                  start_go;
    logic                  active_now;
    logic [15:0]           top16;
    logic [IDXP_W-1:0]     idx_prod;
    logic [KW-1:0]         idx;
    logic [PHASE_BITS-1:0] div_step;
    logic [COUNT_W-1:0]    div_samples;
    logic                  out_free;
    logic                  p2_ready;
    logic                  p1_ready;
    logic [MAG_W-1:0]      rom_mag;
    logic                  rom_neg;
    logic [PROD_W-1:0]     scaled_prod;
    logic [MAG_W-1:0]      level;
    logic signed [SAMPLE_W-1:0] sample;
    logic                  pass;

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [COUNT_W-1:0]    samples_left_reg;
    logic [VOL_W-1:0]      vol_reg;
    logic [FACTOR_W-1:0]   factor_reg;
    logic                  p1_v_reg;
    logic                  p1_active_reg;
    logic [KW-1:0]         p1_idx_reg;
    logic                  p2_v_reg;
    logic                  p2_active_reg;
    logic                  out_valid_reg;
    out_t                  out_data_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign p2_ready = !p2_v_reg || out_free;
    assign p1_ready = !p1_v_reg || p2_ready;
    assign in_ready = p1_ready;

    assign accept     = in_valid && in_ready;
    assign tick_go    = accept && (in_data.op == OP_TICK);
    assign start_go   = accept && (in_data.op == OP_START);
    assign active_now = samples_left_reg != '0;

    assign top16    = phase_acc_reg[PHASE_BITS-1 -: 16];
    assign idx_prod = IDXP_W'(top16) * IDXP_W'(SINE_TABLE_ENTRIES);
    assign idx      = idx_prod[16 +: KW];

    stg_start_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .tone_hz     (in_data.tone_hz),
        .duration_ms (in_data.duration_ms),
        .step        (div_step),
        .samples     (div_samples)
    );

    // tone state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            phase_step_reg   <= '0;
            samples_left_reg <= '0;
        end
        else
        begin
            if (start_go)
            begin
                phase_acc_reg    <= '0;
                phase_step_reg   <= div_step;
                samples_left_reg <= div_samples;
            end
            else if (tick_go && active_now)
            begin
                phase_acc_reg    <= phase_acc_reg + phase_step_reg;
                samples_left_reg <= samples_left_reg - 1'b1;
            end
        end
    end

    // volume register and its reciprocal-scaled factor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg    <= VOL_W'(VOL_FULL);
            factor_reg <= '0;
        end
        else if (cfg_we)
        begin
            vol_reg    <= cfg_wdata;
            factor_reg <= FACTOR_W'(FACTOR_W'(cfg_wdata) * FACTOR_W'(VOL_RECIP));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_ready)
                p1_v_reg <= tick_go;
            if (p2_ready)
                p2_v_reg <= p1_v_reg;
            if (out_free)
                out_valid_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready)
        begin
            p1_active_reg <= active_now;
            p1_idx_reg    <= idx;
        end
        if (p2_ready)
            p2_active_reg <= p1_active_reg;
        if (out_free)
            out_data_reg <= '{sample_out: sample, tone_active: p2_active_reg};
    end

    stg_sine_rom #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_rom (
        .clk   (clk),
        .rd_en (p2_ready),
        .idx   (p1_idx_reg),
        .mag   (rom_mag),
        .neg   (rom_neg)
    );

    // volume scaling, truncated toward zero on the magnitude
    assign pass        = vol_reg >= VOL_W'(VOL_FULL);
    assign scaled_prod = PROD_W'(rom_mag) * PROD_W'(factor_reg);
    assign level       = pass ? rom_mag : scaled_prod[VOL_SHIFT +: MAG_W];

    always_comb
    begin
        if (!p2_active_reg)
            sample = '0;
        else if (rom_neg)
            sample = -$signed({1'b0, level});
        else
            sample = $signed({1'b0, level});
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/stg_checker.sv =====
module stg_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input stg_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input stg_pkg::out_t out_data
);
    import stg_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.tone_active |-> out_data.sample_out == '0)
        else $error("idle sample not zero");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.sample_out <= SAMPLE_W'(AMPLITUDE))
                   && (out_data.sample_out >= -SAMPLE_W'(AMPLITUDE)))
        else $error("sample outside amplitude");

    a_start_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_START |=> in_ready)
        else $error("input stalled after a start request");

endmodule

bind sine_tone_generator_with_volume stg_checker u_stg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== sim/sine_tone_generator_with_volume_test.sv =====
module sine_tone_generator_with_volume_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stg_pkg::*;

    typedef longint unsigned u64_t;

    localparam int   PHASE_W       = PHASE_BITS_DEF;
    localparam u64_t TABLE_N       = SINE_TABLE_ENTRIES_DEF;
    localparam u64_t HALF_PI_Q32   = 64'h1_921F_B544;
    localparam int   MS_PER_S      = 1000;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   CYCLE_LIMIT   = 400000;
    localparam int   IDLE_PCT      = 7;
    localparam int   MAX_REPORTS   = 10;
    localparam int   PHASE_ITEMS   = 170;

    class tone_tracker;
        logic [VOL_W-1:0]   volume       = VOL_W'(VOL_FULL);
        logic [PHASE_W-1:0] phase_acc    = '0;
        logic [PHASE_W-1:0] phase_step   = '0;
        logic [COUNT_W-1:0] samples_left = '0;
        out_t               expected_samples[$];
        int unsigned        mismatches   = 0;

        // 12000 * sin((pi/2) * num / N), truncated, in Q30
        function automatic int quarter_wave(u64_t num);
            u64_t   x, x2, term, d, mag;
            longint sum;
            if (num == 0)
                return 0;
            if (num >= TABLE_N)
                return AMPLITUDE;
            x = ((num * HALF_PI_Q32) / TABLE_N) >> 2;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int i = 1; i <= 7; i++)
            begin
                d = u64_t'((2 * i) * (2 * i + 1));
                term = ((term * x2) >> 30) / d;
                if (i % 2 == 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum <= 0)
                return 0;
            mag = (u64_t'(sum) * AMPLITUDE) >> 30;
            if (mag > AMPLITUDE)
                mag = AMPLITUDE;
            return int'(mag);
        endfunction

        function automatic int sine_entry(u64_t k);
            u64_t quadrant, rem;
            int   v;
            quadrant = (k * 4) / TABLE_N;
            rem = k * 4 - quadrant * TABLE_N;
            v = quadrant[0] ? quarter_wave(TABLE_N - rem) : quarter_wave(rem);
            return quadrant[1] ? -v : v;
        endfunction

        function automatic void take_request(in_t req);
            u64_t hz, k;
            int   sample;
            out_t exp_sample;
            if (req.op == OP_START)
            begin
                hz = req.tone_hz;
                if (hz > NYQUIST_HZ)
                    hz = NYQUIST_HZ;
                phase_acc = '0;
                phase_step = PHASE_W'((hz << PHASE_W) / AUDIO_RATE_HZ);
                samples_left = COUNT_W'((u64_t'(req.duration_ms) * AUDIO_RATE_HZ) / MS_PER_S);
                return;
            end
            sample = 0;
            exp_sample.tone_active = 1'b0;
            if (samples_left != 0)
            begin
                k = (u64_t'(phase_acc >> (PHASE_W - 16)) * TABLE_N) >> 16;
                sample = sine_entry(k);
                phase_acc = phase_acc + phase_step;
                samples_left = samples_left - 1'b1;
                exp_sample.tone_active = 1'b1;
            end
            if (volume < VOL_FULL)
                sample = (sample * int'(volume)) / VOL_FULL;
            exp_sample.sample_out = sample[SAMPLE_W-1:0];
            expected_samples.push_back(exp_sample);
        endfunction

        function automatic void check_sample(out_t got);
            out_t exp_sample;
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sample %0d active %0b", got.sample_out,
                             got.tone_active);
                return;
            end
            exp_sample = expected_samples.pop_front();
            if (got.sample_out !== exp_sample.sample_out
                || got.tone_active !== exp_sample.tone_active)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("sample mismatch: expected %0d active %0b, got %0d active %0b",
                             exp_sample.sample_out, exp_sample.tone_active,
                             got.sample_out, got.tone_active);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [VOL_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;

    tone_tracker tracker = new;
    bit          steady = 1'b0;
    int unsigned cycle_count = 0;

    sine_tone_generator_with_volume dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sine_tone_generator_with_volume_test: errors");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            tracker.check_sample(out_data);

    function automatic in_t make_request(logic op, int hz, int ms);
        in_t req;
        req.op = op;
        req.tone_hz = HZ_W'(hz);
        req.duration_ms = MS_W'(ms);
        return req;
    endfunction

    task automatic push_request(input in_t req);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do @(posedge clk); while (!in_ready);
        tracker.take_request(req);
    endtask

    task automatic push_tick();
        in_t req;
        req = in_t'($urandom);
        req.op = OP_TICK;
        push_request(req);
    endtask

    // wait for every expected sample with the input idle
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_volume(input int vol);
        cfg_we <= 1'b1;
        cfg_wdata <= VOL_W'(vol);
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.volume = VOL_W'(vol);
    endtask

    task automatic random_tones(input int budget);
        int   sent;
        int   hz;
        int   ms;
        int   ticks;
        int   left;
        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(9))
                7:       hz = $urandom_range(0, (1 << HZ_W) - 1);
                8:       hz = $urandom_range(0, 1) ? NYQUIST_HZ : $urandom_range(0, 2) * 11025;
                9:       hz = $urandom_range(NYQUIST_HZ + 1, (1 << HZ_W) - 1);
                default: hz = $urandom_range(0, NYQUIST_HZ);
            endcase
            case ($urandom_range(19))
                14, 15, 16, 17: ms = $urandom_range(3, 5);
                18:             ms = $urandom_range(0, (1 << MS_W) - 1);
                19:             ms = 0;
                default:        ms = $urandom_range(0, 2);
            endcase
            push_request(make_request(OP_START, hz, ms));
            sent++;
            left = (tracker.samples_left > 200) ? 200 : int'(tracker.samples_left);
            case ($urandom_range(9))
                0:       ticks = $urandom_range(0, left);
                1:       ticks = $urandom_range(0, 3);
                default: ticks = left + $urandom_range(0, 4);
            endcase
            repeat (ticks)
            begin
                push_tick();
                sent++;
            end
        end
    endtask

    initial
    begin
        int phase_vol[6];
        phase_vol = '{0, VOL_W'('1), 1, VOL_FULL - 1, VOL_FULL / 2, 0};
        phase_vol[5] = $urandom_range(2, VOL_FULL - 2);

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_ready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle after reset, quadrant points, zero and saturated tones
        push_tick();
        push_request(make_request(OP_START, 0, 0));
        push_tick();
        push_request(make_request(OP_START, 11025, 1));
        repeat (5) push_tick();
        push_request(make_request(OP_START, 0, 1));
        push_tick();
        push_request(make_request(OP_START, (1 << HZ_W) - 1, (1 << MS_W) - 1));
        repeat (3) push_tick();
        push_request(in_t'('1));
        push_request(make_request(OP_START, NYQUIST_HZ, 1));
        repeat (3) push_tick();
        push_request(make_request(OP_START, 1, 0));
        push_tick();
        push_request(make_request(OP_START, 15'h2AAA, 16'h5555));
        push_tick();

        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_volume(phase_vol[p]);
            steady = (p == 2);
            random_tones(PHASE_ITEMS);
            steady = 1'b0;
        end

        settle();
        if (tracker.mismatches == 0 && tracker.expected_samples.size() == 0)
            $display("sine_tone_generator_with_volume_test: clean");
        else
            $display("sine_tone_generator_with_volume_test: errors");
        $finish;
    end

endmodule
